/* src/apdu_parse_and_select_macros.svh */
// assertion macros for the command apdu parser and selector
// used by the top level only; relies on clk and arst_n in the including scope
`ifndef APDU_PARSE_AND_SELECT_MACROS_SVH
`define APDU_PARSE_AND_SELECT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define APS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aps assertion failed");

// next-cycle implication, disabled while in reset
`define APS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aps assertion failed");

`endif

/* src/aps_pkg.sv */
// shared types, sizes and codes of the command apdu parser and selector
// no dependencies
`default_nettype none

package aps_pkg;

	localparam int NUM_APPS  = 4;
	localparam int AID_MAX   = 16;
	localparam int FRAME_MAX = 512;

	localparam int CNT_W  = $clog2(FRAME_MAX + 1);
	localparam int AID_AW = $clog2(AID_MAX);
	localparam int ROW_W  = NUM_APPS * 8;
	localparam int APP_W  = 2;
	localparam int LEN_W  = 5;
	localparam int HDR_MIN = 4;

	localparam logic [7:0] CLA_LOCAL  = 8'h00;
	localparam logic [7:0] INS_SELECT = 8'hA4;
	localparam logic [7:0] P1_BY_NAME = 8'h04;

	localparam logic [15:0] SW_OK        = 16'h9000;
	localparam logic [15:0] SW_SHORT     = 16'h6E00;
	localparam logic [15:0] SW_LENGTH    = 16'h6700;
	localparam logic [15:0] SW_NOT_FOUND = 16'h6A82;
	localparam logic [15:0] SW_BAD_INS   = 16'h6D00;
	localparam logic [15:0] SW_NONE      = 16'h0000;

	typedef enum logic [1:0] {
		CMD_APDU       = 2'd0,
		CMD_AID_BYTE   = 2'd1,
		CMD_APP_SET    = 2'd2,
		CMD_DISCONNECT = 2'd3
	} aps_cmd_t;

	typedef enum logic [1:0] {
		OUT_REPLY   = 2'd0,
		OUT_FORWARD = 2'd1,
		OUT_DISC    = 2'd2
	} aps_outcome_t;

	// one beat held in the input register
	typedef struct packed {
		aps_cmd_t             cmd;
		logic [7:0]           data_byte;
		logic                 last;
		logic [APP_W-1:0]     app_index;
		logic [LEN_W-1:0]     aid_length;
		logic                 app_enable;
		logic [CNT_W-1:0]     pos;
		logic                 take;
	} aps_item_t;

	// one result beat
	typedef struct packed {
		aps_outcome_t     outcome;
		logic [15:0]      status_word;
		logic [7:0]       class_byte;
		logic [7:0]       instr_byte;
		logic [7:0]       param_one;
		logic [7:0]       param_two;
		logic [7:0]       data_length;
		logic [7:0]       max_resp_length;
		logic [APP_W-1:0] current_app;
		logic             app_is_selected;
		logic             selected_now;
		logic             deselected_prev;
	} aps_result_t;

endpackage

`default_nettype wire

/* src/apdu_parse_and_select.sv */
// top level of the command apdu parser and application selector
// uses aps_pkg, aps_in_stage, aps_parse and the assertion macro header
//
// channel | dir | tdata                                         | tuser   | tlast
// s_      | in  | data_byte, app_index, aid_position, aid_length, | cmd     | last
//         |     | app_enable                                    |         |
// m_      | out | status_word .. deselected_prev                | outcome | -
//
// a result beat is registered in the result register after its input beat has passed the input register,
// which reads its table row; one beat a cycle while the output does not stall
// s_tready drops only while the input register is full and the result is not taken
// reset clears counter, header, lengths, presence and selection; identifiers are not cleared
`default_nettype none

`include "apdu_parse_and_select_macros.svh"

module apdu_parse_and_select (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// [7:0] data_byte, [9:8] app_index, [13:10] aid_position, [18:14] aid_length,
	// [19] app_enable, [23:20] zero
	input  wire [23:0]  s_tdata,
	// [1:0] cmd
	input  wire [1:0]   s_tuser,
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	// [15:0] status_word, [23:16] class_byte, [31:24] instr_byte, [39:32] param_one,
	// [47:40] param_two, [55:48] data_length, [63:56] max_resp_length,
	// [65:64] current_app, [66] app_is_selected, [67] selected_now,
	// [68] deselected_prev, [71:69] zero
	output logic [71:0] m_tdata,
	// [1:0] outcome
	output logic [1:0]  m_tuser
);
	import aps_pkg::*;

	logic               advance;
	logic               valid_s1;
	aps_item_t          item_s1;
	logic [ROW_W-1:0]   row_s1;
	aps_result_t        res_q;

	// input register and table lookup
	aps_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.row_s1   (row_s1)
	);

	// parse, select and result register
	aps_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.row_s1      (row_s1),
		.m_tready    (m_tready),
		.advance     (advance),
		.out_valid_q (m_tvalid),
		.res_q       (res_q)
	);

	// result beat packing
	assign m_tuser = res_q.outcome;
	assign m_tdata = {3'b000, res_q.deselected_prev, res_q.selected_now, res_q.app_is_selected,
		res_q.current_app, res_q.max_resp_length, res_q.data_length, res_q.param_two,
		res_q.param_one, res_q.instr_byte, res_q.class_byte, res_q.status_word};

	// checks
	`APS_ASSERT_IMP(a_stall_only_on_output, !s_tready, m_tvalid && !m_tready)
	`APS_ASSERT_IMP(a_disc_clears, m_tvalid && res_q.outcome == OUT_DISC,
		!res_q.app_is_selected && res_q.current_app == '0 && res_q.status_word == SW_NONE)
	`APS_ASSERT_IMP(a_select_ok, m_tvalid && res_q.selected_now,
		res_q.app_is_selected && res_q.status_word == SW_OK && res_q.outcome == OUT_REPLY)
	`APS_ASSERT_IMP(a_forward_needs_sel, m_tvalid && res_q.outcome == OUT_FORWARD,
		res_q.app_is_selected && res_q.status_word == SW_OK)

endmodule

`default_nettype wire

/* src/aps_aid_mem.sv */
// identifier table: one row per byte position, one byte lane per application
// uses aps_pkg for sizes
`default_nettype none

module aps_aid_mem (
	input  wire                         clk,
	input  wire                         wr_en,
	input  wire [aps_pkg::AID_AW-1:0]   wr_addr,
	input  wire [aps_pkg::APP_W-1:0]    wr_lane,
	input  wire [7:0]                   wr_data,
	input  wire                         rd_en,
	input  wire [aps_pkg::AID_AW-1:0]   rd_addr,
	output logic [aps_pkg::ROW_W-1:0]   rd_data_q
);
	import aps_pkg::*;

	logic [ROW_W-1:0] mem_q [AID_MAX];

	// byte-lane write, registered row read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr][wr_lane*8 +: 8] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* src/aps_in_stage.sv */
// input register stage: byte counter, table writes and table row lookup
// uses aps_pkg and aps_aid_mem
`default_nettype none

module aps_in_stage (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire [23:0]                s_tdata,
	input  wire [1:0]                 s_tuser,
	input  wire                       s_tlast,
	input  wire                       advance,
	output logic                      valid_s1,
	output aps_pkg::aps_item_t        item_s1,
	output logic [aps_pkg::ROW_W-1:0] row_s1
);
	import aps_pkg::*;

	logic             accept;
	aps_cmd_t         cmd;
	logic [7:0]       data_byte;
	logic [APP_W-1:0] app_index;
	logic [3:0]       aid_position;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] data_ofs;
	logic             take;
	logic             wr_en;

	// beat unpacking
	assign cmd          = aps_cmd_t'(s_tuser);
	assign data_byte    = s_tdata[7:0];
	assign app_index    = s_tdata[9:8];
	assign aid_position = s_tdata[13:10];

	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;
	assign take     = count_q < CNT_W'(FRAME_MAX);
	assign data_ofs = count_q - CNT_W'(5);

	assign wr_en = accept && (cmd == CMD_AID_BYTE) && (int'(app_index) < NUM_APPS)
		&& (int'(aid_position) < AID_MAX);

	// byte counter and input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (accept) begin
				case (cmd)
					CMD_APDU: begin
						if (s_tlast) begin
							count_q <= '0;
						end else if (take) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					CMD_DISCONNECT: count_q <= '0;
					default: count_q <= count_q;
				endcase
			end
		end
	end

	// payload of the input register
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd        <= cmd;
			item_s1.data_byte  <= data_byte;
			item_s1.last       <= s_tlast;
			item_s1.app_index  <= app_index;
			item_s1.aid_length <= s_tdata[18:14];
			item_s1.app_enable <= s_tdata[19];
			item_s1.pos        <= count_q;
			item_s1.take       <= take;
		end
	end

	// table row for this byte position, read as the beat enters
	aps_aid_mem u_aid_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (aid_position[AID_AW-1:0]),
		.wr_lane   (app_index),
		.wr_data   (data_byte),
		.rd_en     (accept),
		.rd_addr   (data_ofs[AID_AW-1:0]),
		.rd_data_q (row_s1)
	);

endmodule

`default_nettype wire

/* src/aps_parse.sv */
// frame state, prefix match, frame check, selection and result register
// uses aps_pkg; fed by aps_in_stage
`default_nettype none

module aps_parse (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       valid_s1,
	input  aps_pkg::aps_item_t        item_s1,
	input  wire [aps_pkg::ROW_W-1:0]  row_s1,
	input  wire                       m_tready,
	output logic                      advance,
	output logic                      out_valid_q,
	output aps_pkg::aps_result_t      res_q
);
	import aps_pkg::*;

	logic [7:0]        hdr_q [5];
	logic [7:0]        hdr_nx [5];
	logic [7:0]        le_q;
	logic [7:0]        le_nx;
	logic [NUM_APPS-1:0] flags_q;
	logic [NUM_APPS-1:0] flags_nx;
	logic [NUM_APPS-1:0] mism;
	logic [LEN_W-1:0]  len_q [NUM_APPS];
	logic [NUM_APPS-1:0] present_q;
	logic [APP_W-1:0]  sel_idx_q;
	logic              sel_valid_q;
	logic [APP_W-1:0]  sel_idx_nx;
	logic              sel_valid_nx;

	logic              go;
	logic [CNT_W-1:0]  n;
	logic [CNT_W-1:0]  k;
	logic [CNT_W-1:0]  rem;
	logic              in_data;
	logic [7:0]        lc;
	logic [7:0]        le;
	logic              short_frame;
	logic              len_err;
	logic              is_select;
	logic              found;
	logic [APP_W-1:0]  hit_idx;
	logic              has_res;
	logic              restart;
	aps_result_t       res_nx;

	assign advance = !out_valid_q || m_tready;
	assign go      = valid_s1 && advance;

	// header capture and per-application prefix compare
	always_comb begin
		hdr_nx = hdr_q;
		if (item_s1.cmd == CMD_APDU && item_s1.take) begin
			if (item_s1.pos == '0) begin
				for (int j = 0; j < 5; j++) begin
					hdr_nx[j] = 8'h00;
				end
			end
			if (item_s1.pos < CNT_W'(5)) begin
				hdr_nx[item_s1.pos[2:0]] = item_s1.data_byte;
			end
		end
		for (int i = 0; i < NUM_APPS; i++) begin
			mism[i] = row_s1[i*8 +: 8] != item_s1.data_byte;
		end
		k       = item_s1.pos - CNT_W'(5);
		in_data = item_s1.cmd == CMD_APDU && item_s1.take && item_s1.pos >= CNT_W'(5)
			&& k < CNT_W'(hdr_q[4]) && k < CNT_W'(AID_MAX);
		flags_nx = in_data ? (flags_q & ~mism) : flags_q;
		le_nx    = item_s1.take ? item_s1.data_byte : le_q;
	end

	// length check on the closing byte
	always_comb begin
		n   = item_s1.take ? item_s1.pos + CNT_W'(1) : item_s1.pos;
		rem = n - CNT_W'(5);
		lc  = 8'h00;
		le  = 8'h00;
		len_err     = 1'b0;
		short_frame = n < CNT_W'(HDR_MIN);
		if (n == CNT_W'(5)) begin
			le = hdr_nx[4];
		end else if (n > CNT_W'(5)) begin
			lc = hdr_nx[4];
			if (rem < CNT_W'(lc) || rem > CNT_W'(lc) + CNT_W'(1)) begin
				len_err = 1'b1;
			end else if (rem == CNT_W'(lc) + CNT_W'(1)) begin
				le = le_nx;
			end
		end
	end

	// first present entry whose identifier starts with the data
	always_comb begin
		found   = 1'b0;
		hit_idx = '0;
		for (int i = NUM_APPS - 1; i >= 0; i--) begin
			if (present_q[i] && CNT_W'(lc) <= CNT_W'(len_q[i]) && (lc == 8'h00 || flags_nx[i]))
			begin
				found   = 1'b1;
				hit_idx = APP_W'(i);
			end
		end
		is_select = hdr_nx[0] == CLA_LOCAL && hdr_nx[1] == INS_SELECT
			&& hdr_nx[2] == P1_BY_NAME;
	end

	// result and selection update
	always_comb begin
		sel_idx_nx   = sel_idx_q;
		sel_valid_nx = sel_valid_q;
		has_res      = 1'b0;
		restart      = 1'b0;
		res_nx.outcome         = OUT_REPLY;
		res_nx.status_word     = SW_OK;
		res_nx.class_byte      = hdr_nx[0];
		res_nx.instr_byte      = hdr_nx[1];
		res_nx.param_one       = hdr_nx[2];
		res_nx.param_two       = hdr_nx[3];
		res_nx.data_length     = lc;
		res_nx.max_resp_length = le;
		res_nx.selected_now    = 1'b0;
		res_nx.deselected_prev = 1'b0;
		case (item_s1.cmd)
			CMD_APDU: begin
				if (item_s1.last) begin
					has_res = 1'b1;
					restart = 1'b1;
					if (short_frame || len_err) begin
						res_nx.status_word     = short_frame ? SW_SHORT : SW_LENGTH;
						res_nx.data_length     = 8'h00;
						res_nx.max_resp_length = 8'h00;
					end else if (is_select) begin
						if (found) begin
							sel_idx_nx   = hit_idx;
							sel_valid_nx = 1'b1;
							res_nx.selected_now    = 1'b1;
							res_nx.deselected_prev = sel_valid_q;
						end else begin
							res_nx.status_word = SW_NOT_FOUND;
						end
					end else if (sel_valid_q) begin
						res_nx.outcome = OUT_FORWARD;
					end else if (hdr_nx[0] == CLA_LOCAL && hdr_nx[1] != INS_SELECT) begin
						res_nx.status_word = SW_BAD_INS;
					end else begin
						res_nx.status_word = SW_NOT_FOUND;
					end
				end
			end
			CMD_DISCONNECT: begin
				has_res      = 1'b1;
				restart      = 1'b1;
				sel_idx_nx   = '0;
				sel_valid_nx = 1'b0;
				res_nx.outcome         = OUT_DISC;
				res_nx.status_word     = SW_NONE;
				res_nx.class_byte      = 8'h00;
				res_nx.instr_byte      = 8'h00;
				res_nx.param_one       = 8'h00;
				res_nx.param_two       = 8'h00;
				res_nx.data_length     = 8'h00;
				res_nx.max_resp_length = 8'h00;
				res_nx.deselected_prev = sel_valid_q;
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
		res_nx.current_app     = sel_valid_nx ? sel_idx_nx : '0;
		res_nx.app_is_selected = sel_valid_nx;
	end

	// frame, table and selection state, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 5; j++) begin
				hdr_q[j] <= 8'h00;
			end
			for (int i = 0; i < NUM_APPS; i++) begin
				len_q[i] <= '0;
			end
			le_q        <= 8'h00;
			flags_q     <= '1;
			present_q   <= '0;
			sel_idx_q   <= '0;
			sel_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1 && has_res;
			end
			if (go) begin
				hdr_q       <= hdr_nx;
				le_q        <= le_nx;
				flags_q     <= restart ? '1 : flags_nx;
				sel_idx_q   <= sel_idx_nx;
				sel_valid_q <= sel_valid_nx;
				if (item_s1.cmd == CMD_APP_SET && int'(item_s1.app_index) < NUM_APPS) begin
					len_q[item_s1.app_index] <= (item_s1.aid_length > LEN_W'(AID_MAX))
						? LEN_W'(AID_MAX) : item_s1.aid_length;
					present_q[item_s1.app_index] <= item_s1.app_enable;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (go && has_res) begin
			res_q <= res_nx;
		end
	end

endmodule

`default_nettype wire

/* verif/apdu_parse_and_select_tb.sv */
// self-checking bench for the command apdu parser and application selector
// a cycle-free model of the card state predicts every result beat from the input beats
// depends on aps_pkg and the apdu_parse_and_select top level

module apdu_parse_and_select_tb;
	import aps_pkg::*;

	// one input beat as the bench sees it
	typedef struct packed {
		aps_cmd_t           cmd;
		logic [7:0]         data_byte;
		logic               last;
		logic [APP_W-1:0]   app_index;
		logic [AID_AW-1:0]  aid_position;
		logic [LEN_W-1:0]   aid_length;
		logic               app_enable;
	} link_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	int tx_idle_pct = 35;
	int rx_idle_pct = 76;
	int beats_sent = 0;
	int replies_seen = 0;
	int mismatch_count = 0;

	aps_result_t replies_due[$];

	// card state mirrored by the bench
	int          frame_cnt = 0;
	logic [7:0]  hdr [5] = '{default: 8'h00};
	logic [7:0]  le_last = 8'h00;
	logic [NUM_APPS-1:0] match_mask = '1;
	logic [7:0]  aid_tab [NUM_APPS*AID_MAX] = '{default: 8'h00};
	int          aid_len_tab [NUM_APPS] = '{default: 0};
	logic [NUM_APPS-1:0] app_on = '0;
	int          sel_idx = 0;
	bit          sel_valid = 1'b0;

	apdu_parse_and_select dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// result beats
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_reply(m_tdata, m_tuser);
	end

	// run limit
	initial begin
		#(12 * 500000);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("reply %0d %s got %h want %h",
				replies_seen, name, got, want));
	endtask

	task automatic check_reply(input logic [71:0] d, input logic [1:0] u);
		aps_result_t want;
		if (replies_due.size() == 0) begin
			report_mismatch($sformatf("reply %0d arrived with none pending", replies_seen));
		end else begin
			want = replies_due.pop_front();
			compare_field("outcome", u, want.outcome);
			compare_field("status_word", d[15:0], want.status_word);
			compare_field("class_byte", d[23:16], want.class_byte);
			compare_field("instr_byte", d[31:24], want.instr_byte);
			compare_field("param_one", d[39:32], want.param_one);
			compare_field("param_two", d[47:40], want.param_two);
			compare_field("data_length", d[55:48], want.data_length);
			compare_field("max_resp_length", d[63:56], want.max_resp_length);
			compare_field("current_app", d[65:64], want.current_app);
			compare_field("app_is_selected", d[66], want.app_is_selected);
			compare_field("selected_now", d[67], want.selected_now);
			compare_field("deselected_prev", d[68], want.deselected_prev);
		end
		replies_seen++;
	endtask

	// reply built from the captured header and the current selection
	function automatic aps_result_t make_reply(input aps_outcome_t oc, input logic [15:0] sw,
			input int lc, input int le, input bit sel_now, input bit desel);
		aps_result_t r;
		bit keep_hdr;
		keep_hdr = (oc != OUT_DISC);
		r.outcome = oc;
		r.status_word = sw;
		r.class_byte = keep_hdr ? hdr[0] : 8'h00;
		r.instr_byte = keep_hdr ? hdr[1] : 8'h00;
		r.param_one = keep_hdr ? hdr[2] : 8'h00;
		r.param_two = keep_hdr ? hdr[3] : 8'h00;
		r.data_length = 8'(lc);
		r.max_resp_length = 8'(le);
		r.current_app = sel_valid ? APP_W'(sel_idx) : '0;
		r.app_is_selected = sel_valid;
		r.selected_now = sel_now;
		r.deselected_prev = desel;
		return r;
	endfunction

	// one apdu byte into the frame, with the identifier compare on data bytes
	function automatic void frame_take(input logic [7:0] b);
		int k;
		int i;
		if (frame_cnt >= FRAME_MAX)
			return;
		if (frame_cnt == 0) begin
			for (i = 0; i < 5; i++)
				hdr[i] = 8'h00;
		end
		if (frame_cnt < 5) begin
			hdr[frame_cnt] = b;
		end else begin
			k = frame_cnt - 5;
			if (k < hdr[4] && k < AID_MAX) begin
				for (i = 0; i < NUM_APPS; i++)
					if (aid_tab[i*AID_MAX + k] != b)
						match_mask[i] = 1'b0;
			end
		end
		le_last = b;
		frame_cnt++;
	endfunction

	// closes the frame: length checks, select by name, forward or local answer
	function automatic aps_result_t close_frame();
		int n;
		int lc;
		int le;
		int rem;
		int i;
		bit prev;
		n = frame_cnt;
		lc = 0;
		le = 0;
		if (n < HDR_MIN)
			return make_reply(OUT_REPLY, SW_SHORT, 0, 0, 0, 0);
		if (n == 5) begin
			le = hdr[4];
		end else if (n > 5) begin
			rem = n - 5;
			lc = hdr[4];
			if (rem < lc || rem > lc + 1)
				return make_reply(OUT_REPLY, SW_LENGTH, 0, 0, 0, 0);
			if (rem == lc + 1)
				le = le_last;
		end
		if (hdr[0] == CLA_LOCAL && hdr[1] == INS_SELECT && hdr[2] == P1_BY_NAME) begin
			for (i = 0; i < NUM_APPS; i++) begin
				if (app_on[i] && lc <= aid_len_tab[i] && (lc == 0 || match_mask[i])) begin
					prev = sel_valid;
					sel_idx = i;
					sel_valid = 1'b1;
					return make_reply(OUT_REPLY, SW_OK, lc, le, 1, prev);
				end
			end
			return make_reply(OUT_REPLY, SW_NOT_FOUND, lc, le, 0, 0);
		end
		if (sel_valid)
			return make_reply(OUT_FORWARD, SW_OK, lc, le, 0, 0);
		if (hdr[0] == CLA_LOCAL && hdr[1] != INS_SELECT)
			return make_reply(OUT_REPLY, SW_BAD_INS, lc, le, 0, 0);
		return make_reply(OUT_REPLY, SW_NOT_FOUND, lc, le, 0, 0);
	endfunction

	// card state update for one accepted beat, queuing any reply it causes
	function automatic void update_card_state(input link_beat_t b);
		bit prev;
		case (b.cmd)
			CMD_APDU: begin
				frame_take(b.data_byte);
				if (b.last) begin
					replies_due.push_back(close_frame());
					frame_cnt = 0;
					match_mask = '1;
				end
			end
			CMD_AID_BYTE: begin
				aid_tab[b.app_index*AID_MAX + b.aid_position] = b.data_byte;
			end
			CMD_APP_SET: begin
				aid_len_tab[b.app_index] = (int'(b.aid_length) > AID_MAX) ? AID_MAX
					: int'(b.aid_length);
				app_on[b.app_index] = b.app_enable;
			end
			default: begin
				prev = sel_valid;
				sel_valid = 1'b0;
				sel_idx = 0;
				frame_cnt = 0;
				match_mask = '1;
				replies_due.push_back(make_reply(OUT_DISC, SW_NONE, 0, 0, 0, prev));
			end
		endcase
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// beat with every field random, the caller fixes the ones that matter
	function automatic link_beat_t make_beat(input aps_cmd_t c);
		link_beat_t b;
		b.cmd = c;
		b.data_byte = rand_byte();
		b.last = 1'($urandom_range(1));
		b.app_index = APP_W'($urandom_range(NUM_APPS - 1));
		b.aid_position = AID_AW'($urandom_range(AID_MAX - 1));
		b.aid_length = LEN_W'($urandom_range(AID_MAX));
		b.app_enable = 1'($urandom_range(1));
		return b;
	endfunction

	// drives one beat and waits for it to be taken
	task automatic send_beat(input link_beat_t b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= b.cmd;
		s_tlast <= b.last;
		s_tdata <= {4'h0, b.app_enable, b.aid_length, b.aid_position, b.app_index,
			b.data_byte};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		update_card_state(b);
		beats_sent++;
	endtask

	task automatic send_apdu_byte(input logic [7:0] val, input logic last_byte);
		link_beat_t b;
		b = make_beat(CMD_APDU);
		b.data_byte = val;
		b.last = last_byte;
		send_beat(b);
	endtask

	task automatic send_aid_byte(input int idx, input int pos, input logic [7:0] val);
		link_beat_t b;
		b = make_beat(CMD_AID_BYTE);
		b.app_index = APP_W'(idx);
		b.aid_position = AID_AW'(pos);
		b.data_byte = val;
		send_beat(b);
	endtask

	task automatic send_app_entry(input int idx, input int len, input logic en);
		link_beat_t b;
		b = make_beat(CMD_APP_SET);
		b.app_index = APP_W'(idx);
		b.aid_length = LEN_W'(len);
		b.app_enable = en;
		send_beat(b);
	endtask

	task automatic send_disconnect();
		send_beat(make_beat(CMD_DISCONNECT));
	endtask

	task automatic send_frame(input logic [7:0] f[$]);
		int i;
		for (i = 0; i < f.size(); i++)
			send_apdu_byte(f[i], i == f.size() - 1);
	endtask

	// sender holds off until every pending reply is out
	task automatic drain_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (replies_due.size() != 0)
			@(posedge clk);
	endtask

	// mostly well formed frames, some select by a table prefix, some broken
	task automatic send_random_frame();
		logic [7:0] f[$];
		int kind;
		int lc;
		int entry;
		int k;
		int extra;
		bit with_le;
		kind = $urandom_range(99);
		with_le = 1'($urandom_range(1));
		lc = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(AID_MAX + 2);
		entry = $urandom_range(NUM_APPS - 1);
		if (kind < 40) begin
			lc = $urandom_range(aid_len_tab[entry]);
			f = '{CLA_LOCAL, INS_SELECT, P1_BY_NAME, rand_byte()};
		end else if (kind < 55) begin
			f = '{CLA_LOCAL, INS_SELECT,
				($urandom_range(3) == 0) ? rand_byte() : P1_BY_NAME, rand_byte()};
		end else begin
			f = '{$urandom_range(1) ? CLA_LOCAL : rand_byte(),
				($urandom_range(4) == 0) ? INS_SELECT : rand_byte(), rand_byte(), rand_byte()};
		end
		if (kind >= 88) begin
			if ($urandom_range(1)) begin
				// short frame
				k = $urandom_range(1, 3);
				while (f.size() > k)
					void'(f.pop_back());
			end else begin
				// body too short or too long for lc
				lc = $urandom_range(1, 20);
				extra = $urandom_range(1) ? $urandom_range(lc - 1) : lc + 2 + $urandom_range(3);
				f.push_back(8'(lc));
				repeat (extra)
					f.push_back(rand_byte());
			end
		end else begin
			if (lc != 0) begin
				f.push_back(8'(lc));
				for (k = 0; k < lc; k++)
					f.push_back((kind < 40) ? aid_tab[entry*AID_MAX + k] : rand_byte());
				// spoil one identifier byte now and then
				if (kind < 40 && $urandom_range(4) == 0) begin
					k = 4 + $urandom_range(1, lc);
					f[k] = ~f[k];
				end
			end
			if (with_le)
				f.push_back(rand_byte());
		end
		send_frame(f);
	endtask

	// every identifier byte written before any select can read it
	task automatic test_load_identifiers();
		int i;
		int p;
		for (i = 0; i < NUM_APPS; i++)
			for (p = 0; p < AID_MAX; p++)
				send_aid_byte(i, p, rand_byte());
		send_app_entry(0, 8, 1'b1);
		send_app_entry(1, AID_MAX, 1'b1);
		send_app_entry(2, 0, 1'b0);
		// overlong length saturates
		send_app_entry(3, 31, 1'b1);
	endtask

	task automatic test_directed_cases();
		logic [7:0] f[$];
		// short frame of one byte
		f = '{8'hFF};
		send_frame(f);
		// header only, nonzero class with nothing selected
		f = '{8'h80, 8'hCA, 8'h9F, 8'h7F};
		send_frame(f);
		// unknown instruction, le only
		f = '{CLA_LOCAL, 8'hB0, 8'h00, 8'hFF, 8'h00};
		send_frame(f);
		// length errors: data byte missing, then a byte past le
		f = '{CLA_LOCAL, INS_SELECT, P1_BY_NAME, 8'h00, 8'h02, 8'h11};
		send_frame(f);
		f = '{CLA_LOCAL, INS_SELECT, P1_BY_NAME, 8'h00, 8'h01, 8'h11, 8'h22, 8'h33};
		send_frame(f);
		// select with no data takes the lowest present entry
		f = '{CLA_LOCAL, INS_SELECT, P1_BY_NAME, 8'h0C};
		send_frame(f);
		// removing the selected entry keeps it selected, so this is forwarded
		send_app_entry(0, AID_MAX, 1'b0);
		f = '{CLA_LOCAL, 8'hB0, 8'h00, 8'h00};
		send_frame(f);
		// disconnect in the middle of a frame, then with nothing selected
		send_apdu_byte(CLA_LOCAL, 1'b0);
		send_apdu_byte(INS_SELECT, 1'b0);
		send_disconnect();
		send_disconnect();
		send_app_entry(0, 8, 1'b1);
	endtask

	// longest identifier, largest lc and a frame past capacity
	task automatic test_long_frames();
		logic [7:0] f[$];
		int k;
		f = '{CLA_LOCAL, INS_SELECT, P1_BY_NAME, 8'h00, 8'(AID_MAX)};
		for (k = 0; k < AID_MAX; k++)
			f.push_back(aid_tab[AID_MAX + k]);
		f.push_back(8'hFF);
		send_frame(f);
		f = '{8'h80, 8'hE2, 8'h00, 8'h00, 8'hFF};
		repeat (255)
			f.push_back(rand_byte());
		f.push_back(8'hFF);
		send_frame(f);
		// bytes past capacity are dropped, the last mark still closes the frame
		f = {};
		repeat (FRAME_MAX + 8)
			f.push_back(rand_byte());
		send_frame(f);
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_beats);
		int start;
		int r;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = beats_sent;
		while (beats_sent - start < n_beats) begin
			r = $urandom_range(99);
			if (r < 62) begin
				send_random_frame();
			end else if (r < 72) begin
				send_aid_byte($urandom_range(NUM_APPS - 1), $urandom_range(AID_MAX - 1),
					rand_byte());
			end else if (r < 80) begin
				send_app_entry($urandom_range(NUM_APPS - 1), $urandom_range(AID_MAX),
					$urandom_range(4) != 0);
			end else if (r < 86) begin
				send_disconnect();
			end else if (r < 90) begin
				// frame cut off by a disconnect
				repeat ($urandom_range(1, 8))
					send_apdu_byte(rand_byte(), 1'b0);
				send_disconnect();
			end else if (r < 99) begin
				send_beat(make_beat(aps_cmd_t'($urandom_range(3))));
			end else begin
				drain_replies();
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_identifiers();
		test_directed_cases();
		test_long_frames();
		test_random_traffic(35, 76, 280);
		drain_replies();
		test_random_traffic(76, 35, 280);
		drain_replies();
		test_random_traffic(0, 0, 280);
		drain_replies();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* files.f */
+incdir+src
src/aps_pkg.sv
src/aps_aid_mem.sv
src/aps_in_stage.sv
src/aps_parse.sv
src/apdu_parse_and_select.sv
verif/apdu_parse_and_select_tb.sv
